/* src/lkv_pkg.sv */
// Package for the LRU key-value cache: payload structs, widths and constants.
// Depends on nothing; every other file of the block but lkv_fifo imports it.
package lkv_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_W           = 5;
    localparam int DATA_W          = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(16);
    localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } rsp_t;

endpackage

/* src/lkv_fifo.sv */
// Small synchronous queue used for the request and the result side.
// Depends on nothing outside itself; DEPTH must be a power of two, at least 2.
module lkv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store an entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* src/lkv_back.sv */
// Execution engine of the LRU cache: key match array, recency ranks, value memory.
// Depends on lkv_pkg; takes requests from the front queue, writes the result queue.
module lkv_back
    import lkv_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] cap,
    input  logic             in_empty,
    input  req_t             req,
    output logic             in_pop,
    input  logic             out_full,
    output logic             out_push,
    output rsp_t             rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    typedef enum logic [1:0] {
        S_LOOKUP = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Entry state
    logic [DATA_W-1:0] key_reg   [MAX_ENTRIES];
    logic [DATA_W-1:0] value_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]  rank_reg  [MAX_ENTRIES];
    logic [CNT_W-1:0]  count_reg;

    // Lookup results held for the update cycle
    req_t              req_reg;
    logic              hit_reg;
    logic              insert_reg;
    logic              evict_reg;
    logic              act_reg;
    logic              bump_all_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [IDX_W-1:0]  old_rank_reg;
    logic [DATA_W-1:0] evk_reg;
    logic [DATA_W-1:0] rd_data_reg;

    // Lookup decode
    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] lru_vec;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  lru_idx;
    logic [IDX_W-1:0]  lru_rank;
    logic [DATA_W-1:0] lru_key;
    logic              hit;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_eff;
    logic              has_room;
    logic              lookup_fire;
    logic              insert_now;
    logic              evict_now;
    logic              act_now;
    logic [IDX_W-1:0]  slot_now;
    logic [IDX_W-1:0]  old_rank_now;

    assign lookup_fire = (state_reg == S_LOOKUP) && !in_empty && !out_full;
    assign in_pop      = lookup_fire;
    assign out_push    = (state_reg == S_UPDATE);

    // Compare every stored key and locate the oldest entry
    assign lru_rank = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        lru_key  = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            match[i]   = valid_reg[i] && (key_reg[i] == req.key);
            lru_vec[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (lru_vec[i])
            begin
                lru_idx = IDX_W'(i);
                lru_key = lru_key | key_reg[i];
            end
        end
    end

    assign hit = |match;

    // Clamp the capacity register into 1..MAX_ENTRIES
    assign cap_ext  = CMP_W'(cap);
    assign cap_eff  = (cap_ext == '0) ? CMP_W'(1) :
                      ((cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext);
    assign has_room = CMP_W'(count_reg) < cap_eff;

    // Classify the request
    always_comb
    begin
        insert_now   = 1'b0;
        evict_now    = 1'b0;
        act_now      = 1'b0;
        slot_now     = hit_idx;
        old_rank_now = rank_reg[hit_idx];
        if (hit)
        begin
            act_now = 1'b1;
        end
        else if (req.mode == MODE_PUT)
        begin
            act_now = 1'b1;
            if (has_room)
            begin
                insert_now = 1'b1;
                slot_now   = free_idx;
            end
            else
            begin
                evict_now    = 1'b1;
                slot_now     = lru_idx;
                old_rank_now = lru_rank;
            end
        end
    end

    // Sequence lookup and update
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOOKUP:
            begin
                if (lookup_fire)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_LOOKUP;
            end
            default:
            begin
                state_next = S_LOOKUP;
            end
        endcase
    end

    // Control state, valid bits, ranks and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOOKUP;
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_UPDATE) && act_reg)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (IDX_W'(i) == slot_reg)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && (bump_all_reg || (rank_reg[i] < old_rank_reg)))
                    begin
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end
                end
                if (insert_reg)
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    count_reg           <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Hold the lookup outcome
    always_ff @(posedge clk)
    begin
        if (lookup_fire)
        begin
            req_reg      <= req;
            hit_reg      <= hit;
            insert_reg   <= insert_now;
            evict_reg    <= evict_now;
            act_reg      <= act_now;
            bump_all_reg <= insert_now;
            slot_reg     <= slot_now;
            old_rank_reg <= old_rank_now;
            evk_reg      <= lru_key;
        end
    end

    // Write keys on insert or replacement
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_UPDATE) && (insert_reg || evict_reg))
        begin
            key_reg[slot_reg] <= req_reg.key;
        end
    end

    // Value memory: read at the hit slot during lookup, write on put
    always_ff @(posedge clk)
    begin
        if (lookup_fire)
        begin
            rd_data_reg <= value_mem[hit_idx];
        end
        if ((state_reg == S_UPDATE) && (req_reg.mode == MODE_PUT))
        begin
            value_mem[slot_reg] <= req_reg.value;
        end
    end

    // Build the result transaction
    always_comb
    begin
        rsp.found       = hit_reg;
        rsp.evicted     = evict_reg;
        rsp.evicted_key = evict_reg ? evk_reg : '0;
        if (req_reg.mode == MODE_PUT)
        begin
            rsp.read_value = '0;
        end
        else
        begin
            rsp.read_value = hit_reg ? rd_data_reg : READ_MISS;
        end
    end

endmodule

/* src/lru_key_value_cache.sv */
// LRU key-value cache top level: request queue, execution engine, result queue.
// Depends on lkv_pkg, lkv_fifo and lkv_back.
// Flow: a request passes the request queue, the engine's lookup and update steps, then the result queue.
// The engine takes no new request before the update of the last one is done, nor while the result queue is full.
// Reset: clears valid bits, ranks, occupancy and both queues; capacity returns to 16.
// Keys and values need no clearing pass; entries are read only while valid.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             push,
    input  req_t             req,
    output logic             full,
    input  logic             pop,
    output rsp_t             rsp,
    output logic             empty
);

    logic [CFG_W-1:0] cap_reg;
    logic             in_empty;
    logic             in_pop;
    req_t             in_req;
    logic             out_full;
    logic             out_push;
    rsp_t             out_rsp;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Front: request queue
    lkv_fifo #(
        .WIDTH ($bits(req_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (req),
        .full  (full),
        .pop   (in_pop),
        .rdata (in_req),
        .empty (in_empty)
    );

    // Back: lookup and update engine
    lkv_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cap      (cap_reg),
        .in_empty (in_empty),
        .req      (in_req),
        .in_pop   (in_pop),
        .out_full (out_full),
        .out_push (out_push),
        .rsp      (out_rsp)
    );

    // Result queue
    lkv_fifo #(
        .WIDTH ($bits(rsp_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_rsp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_rsp),
        .full  (out_full),
        .pop   (pop),
        .rdata (rsp),
        .empty (empty)
    );

    // Engine never writes a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) out_push |-> !out_full)
        else $error("result pushed into full queue");

    // Engine pops no request during the update step of the one before
    assert property (@(posedge clk) disable iff (!rst_n) in_pop |=> !in_pop)
        else $error("back-to-back request pop");

    // Eviction happens only on a put miss
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.evicted) |-> (!rsp.found && (rsp.read_value == '0)))
        else $error("eviction reported on hit or get");

    // Evicted key is zero when nothing was evicted
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rsp.evicted) |-> (rsp.evicted_key == '0))
        else $error("stray evicted key");

endmodule

/* sim/lkv_checker.sv */
// Checker for the LRU key-value cache: watches the request, result and config channels,
// keeps its own model of the cache contents and recency, and compares every result.
// Depends on lkv_pkg for the payload structs, widths and mode codes.
`timescale 1ns / 1ps

module lkv_checker
    import lkv_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             push,
    input  req_t             req,
    input  logic             full,
    input  logic             pop,
    input  rsp_t             rsp,
    input  logic             empty,
    output int               pending,
    output int               mismatches
);

    // Shadow copy of the cache: keys, values, valid bits and recency ranks
    logic [DATA_W-1:0] slot_key   [MAX_ENTRIES];
    logic [DATA_W-1:0] slot_value [MAX_ENTRIES];
    logic              slot_valid [MAX_ENTRIES];
    int                slot_rank  [MAX_ENTRIES];
    logic [CFG_W-1:0]  capacity_reg;

    rsp_t expected_rsp_q[$];
    rsp_t oldest_rsp;
    int   rsp_index;

    initial mismatches = 0;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h (result %0d, t=%0t)",
                 what, got, want, rsp_index, $time);
        mismatches++;
    endtask

    // Make slot s the most recent; valid slots more recent than it move back one
    function automatic void promote_slot(input int s, input int old_rank);
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (i != s && slot_valid[i] && slot_rank[i] < old_rank)
                slot_rank[i]++;
        end
        slot_rank[s] = 0;
    endfunction

    // Apply one request to the shadow cache and return the result it must produce
    function automatic rsp_t lookup_and_update(input req_t r);
        int   count;
        int   hit;
        int   free_slot;
        int   lru;
        int   lru_rank;
        int   cap;
        rsp_t res;
        res       = '0;
        count     = 0;
        hit       = -1;
        free_slot = -1;
        lru       = -1;
        lru_rank  = 0;
        cap       = int'(capacity_reg);
        if (cap < 1)
            cap = 1;
        if (cap > MAX_ENTRIES)
            cap = MAX_ENTRIES;

        // Scan all slots: occupancy, hit, first free slot, least recent entry
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (slot_valid[i])
            begin
                count++;
                if (slot_key[i] == r.key && hit < 0)
                    hit = i;
                if (lru < 0 || slot_rank[i] >= lru_rank)
                begin
                    lru      = i;
                    lru_rank = slot_rank[i];
                end
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end

        if (hit >= 0)
        begin
            res.found = 1'b1;
            if (r.mode == MODE_GET)
                res.read_value = slot_value[hit];
            else
                slot_value[hit] = r.value;
            promote_slot(hit, slot_rank[hit]);
        end
        else if (r.mode == MODE_GET)
        begin
            res.read_value = READ_MISS;
        end
        else if (count < cap && free_slot >= 0)
        begin
            slot_key[free_slot]   = r.key;
            slot_value[free_slot] = r.value;
            promote_slot(free_slot, MAX_ENTRIES);
            slot_valid[free_slot] = 1'b1;
        end
        else if (lru >= 0)
        begin
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[lru];
            slot_key[lru]   = r.key;
            slot_value[lru] = r.value;
            promote_slot(lru, slot_rank[lru]);
        end
        return res;
    endfunction

    // Track config writes, predict on accepted requests, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            capacity_reg = CFG_RESET;
            expected_rsp_q.delete();
            rsp_index = 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg = cfg_wdata;

            if (push && !full)
                expected_rsp_q.push_back(lookup_and_update(req));

            if (pop && !empty)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    report_mismatch("result with no request waiting", rsp.read_value, '0);
                end
                else
                begin
                    oldest_rsp = expected_rsp_q.pop_front();
                    if (rsp.found !== oldest_rsp.found)
                        report_mismatch("found", DATA_W'(rsp.found),
                                        DATA_W'(oldest_rsp.found));
                    if (rsp.read_value !== oldest_rsp.read_value)
                        report_mismatch("read_value", rsp.read_value, oldest_rsp.read_value);
                    if (rsp.evicted !== oldest_rsp.evicted)
                        report_mismatch("evicted", DATA_W'(rsp.evicted),
                                        DATA_W'(oldest_rsp.evicted));
                    if (rsp.evicted_key !== oldest_rsp.evicted_key)
                        report_mismatch("evicted_key", rsp.evicted_key,
                                        oldest_rsp.evicted_key);
                end
                rsp_index++;
            end

            pending <= expected_rsp_q.size();
        end
    end

endmodule

/* sim/testbench.sv */
// Top of the LRU key-value cache testbench: clock, reset, request and config stimulus,
// random result back-pressure and the verdict. Depends on lkv_pkg, lkv_checker and the block.
`timescale 1ns / 1ps

module testbench;
    import lkv_pkg::*;

    localparam int ITEMS_PER_PHASE = 140;
    localparam int DRAIN_CYCLES    = 12;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             push      = 1'b0;
    req_t             req       = '0;
    logic             full;
    logic             pop       = 1'b0;
    rsp_t             rsp;
    logic             empty;

    int   pending;
    int   mismatches;
    int   cycle_count = 0;
    logic tx_steady   = 1'b0;

    logic signed [DATA_W-1:0] key_pool[$];

    lru_key_value_cache u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .req       (req),
        .full      (full),
        .pop       (pop),
        .rsp       (rsp),
        .empty     (empty)
    );

    lkv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .req        (req),
        .full       (full),
        .pop        (pop),
        .rsp        (rsp),
        .empty      (empty),
        .pending    (pending),
        .mismatches (mismatches)
    );

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Result side: stall at random, about 8 in 100, never inside the steady window
    always @(posedge clk)
    begin
        if (cycle_count >= 2000 && cycle_count < 2800)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(99) >= 8);
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Drive one request and hold it until the block takes the transaction
    task automatic send_request(input logic mode, input logic signed [DATA_W-1:0] key,
                                input logic signed [DATA_W-1:0] value);
        while (!tx_steady && $urandom_range(99) < 8)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req  <= '{mode: mode, key: key, value: value};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Hold off requests until every outstanding transaction has come back
    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write the capacity register while the block is idle
    task automatic set_capacity(input logic [CFG_W-1:0] cap);
        wait_for_drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 32'sh7FFF_FFFF;
        if (roll < 10)
            return 32'sh8000_0000;
        return $urandom;
    endfunction

    // Stimulus: directed corners, then random phases over several capacities
    initial
    begin
        int phase_caps[11];
        int eff_cap;
        int pool_size;
        logic signed [DATA_W-1:0] key;
        phase_caps = '{16, 1, 3, 31, 8, 0, 16, 5, 17, 2, 12};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty cache, fills, hits, value update, extreme keys and values
        send_request(MODE_GET, 32'sh0000_0000, 32'sh1234_5678);
        send_request(MODE_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(MODE_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(MODE_GET, 32'sh8000_0000, 32'sh0000_0000);
        send_request(MODE_GET, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
        send_request(MODE_PUT, 32'sh8000_0000, 32'sh0000_0000);
        send_request(MODE_GET, 32'sh8000_0000, 32'sh5555_5555);
        send_request(MODE_PUT, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_request(MODE_GET, 32'shFFFF_FFFF, 32'sh0000_0000);
        send_request(MODE_GET, 32'sh0000_0001, 32'shAAAA_AAAA);

        // Capacity lowered below occupancy: each put miss evicts only the oldest
        set_capacity(5'd2);
        send_request(MODE_PUT, 32'sh0000_0005, 32'sh0000_0055);
        send_request(MODE_PUT, 32'sh0000_0006, 32'sh0000_0066);
        send_request(MODE_GET, 32'sh7FFF_FFFF, 32'sh0000_0000);
        send_request(MODE_GET, 32'sh0000_0006, 32'sh0000_0000);

        // Zero capacity acts as one entry
        set_capacity(5'd0);
        send_request(MODE_PUT, 32'sh0000_0007, 32'sh0000_0077);
        send_request(MODE_PUT, 32'sh0000_0008, 32'sh0000_0088);
        send_request(MODE_GET, 32'sh0000_0008, 32'sh0000_0000);
        send_request(MODE_GET, 32'sh0000_0007, 32'sh0000_0000);

        // Capacity above the table size acts as the table size
        set_capacity(5'd31);
        send_request(MODE_PUT, 32'sh0000_0009, 32'sh0000_0099);
        send_request(MODE_GET, 32'sh0000_0009, 32'sh0000_0000);
        send_request(MODE_PUT, 32'sh0000_0008, 32'shDEAD_BEEF);
        send_request(MODE_GET, 32'sh0000_0008, 32'sh0000_0000);

        // Random phases: keys drawn mostly from a pool a little larger than capacity
        for (int p = 0; p < 11; p++)
        begin
            set_capacity(CFG_W'(phase_caps[p]));
            eff_cap = phase_caps[p];
            if (eff_cap < 1)
                eff_cap = 1;
            if (eff_cap > MAX_ENTRIES_DEF)
                eff_cap = MAX_ENTRIES_DEF;
            pool_size = eff_cap + $urandom_range(1, 4);
            key_pool.delete();
            for (int j = 0; j < pool_size; j++)
            begin
                if (j == 0)
                    key_pool.push_back(32'sh8000_0000);
                else if (j == 1)
                    key_pool.push_back(32'sh7FFF_FFFF);
                else
                    key_pool.push_back($urandom);
            end
            tx_steady <= (p == 4);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 2 && n == ITEMS_PER_PHASE / 2)
                    wait_for_drain();
                if ($urandom_range(99) < 10)
                    key = $urandom;
                else
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                send_request(1'($urandom_range(1)), key, pick_value());
            end
        end

        // Drain, then give any stray result time to show up
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
src/lkv_pkg.sv
src/lkv_fifo.sv
src/lkv_back.sv
src/lru_key_value_cache.sv
sim/lkv_checker.sv
sim/testbench.sv
